[src/sab_pkg.sv]
// sab_pkg: shared constants and types for the suffix automaton builder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sab_pkg;
  localparam int MAX_LEN   = 1024;
  localparam int ALPHABET  = 26;
  localparam int SW        = 11;                 // state index / length width
  localparam int CW        = 5;                  // symbol / column width
  localparam int TAW       = SW + CW;            // transition address width
  localparam int NSTATES   = 2 * MAX_LEN;
  localparam logic [SW-1:0] LAST_COUNT = SW'(NSTATES - 2);
  localparam logic [SW-1:0] LEN_LIMIT  = SW'(MAX_LEN);
  localparam logic [CW-1:0] LAST_COL   = CW'(ALPHABET - 1);
  localparam logic [CW-1:0] SYM_LIMIT  = CW'(ALPHABET);

  typedef logic [SW-1:0] state_t;
endpackage
`default_nettype wire

[src/sab_ram.sv]
// sab_ram: single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sab_ram #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/suffix_automaton_builder.sv]
// suffix_automaton_builder: online suffix automaton, one symbol per word
// depends on sab_pkg and sab_ram (transition, length and link memories)
// per word: the new state's row is cleared, then the suffix-link walk from the last state
//   adds transitions until it meets one; a clone, when needed, gets the row copied and a
//   redirect walk follows; a restart first clears the root row
// throughput: one word at a time; a new word is taken only once the last result is registered
// reset: synchronous; a pass clears the root row, tready low meanwhile
`timescale 1ns / 1ps
`default_nettype none
module suffix_automaton_builder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // symbol[4:0]
  input  wire logic [0:0]  s_tuser,   // restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // new_state, prefix_length, suffix_link, new_substrings
  output logic [1:0]       m_tuser    // clone_made, overflow
);
  localparam logic [4:0] S_IDLE  = 5'd0,  S_START = 5'd1,  S_CLR   = 5'd2,
                         S_W_RD  = 5'd3,  S_W_CHK = 5'd4,  S_W_LNK = 5'd5,
                         S_Q2    = 5'd6,  S_Q3    = 5'd7,  S_CL1   = 5'd8,
                         S_CL2   = 5'd9,  S_CL3   = 5'd10, S_CP_RD = 5'd11,
                         S_CP_WR = 5'd12, S_R_RD  = 5'd13, S_R_CHK = 5'd14,
                         S_R_LNK = 5'd15, S_DONE  = 5'd16;

  logic [4:0] st, ret;
  logic [sab_pkg::CW-1:0] sym, col;
  sab_pkg::state_t p, q, cur, cl, sc, last, clr_row;
  sab_pkg::state_t last_len, last_link, cur_len, cl_len, len_q;
  sab_pkg::state_t r_state, r_len, r_link, r_sub;
  logic r_clone, r_ovf, o_valid;
  logic [43:0] o_data;
  logic [1:0] o_user;

  logic tr_we, len_we, lk_we;
  logic [sab_pkg::TAW-1:0] tr_addr;
  sab_pkg::state_t tr_wd, tr_rd, len_addr, len_wd, len_rd, lk_addr, lk_wd, lk_rd;
  sab_pkg::state_t len_p;

  sab_ram #(.AW(sab_pkg::TAW), .DW(sab_pkg::SW)) u_tr (
    .clk(clk), .we(tr_we), .addr(tr_addr), .wdata(tr_wd), .rdata(tr_rd));
  sab_ram #(.AW(sab_pkg::SW), .DW(sab_pkg::SW)) u_len (
    .clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wd), .rdata(len_rd));
  sab_ram #(.AW(sab_pkg::SW), .DW(sab_pkg::SW)) u_lk (
    .clk(clk), .we(lk_we), .addr(lk_addr), .wdata(lk_wd), .rdata(lk_rd));

  // the root length is never stored
  assign len_p = (p == '0) ? '0 : len_rd;

  assign s_tready = (st == S_IDLE);
  assign m_tvalid = o_valid;
  assign m_tdata  = {4'd0, o_data};
  assign m_tuser  = o_user;

  always_comb begin
    tr_we = 1'b0; tr_addr = {p, sym}; tr_wd = cur;
    len_we = 1'b0; len_addr = p; len_wd = sab_pkg::state_t'(last_len + 1'b1);
    lk_we = 1'b0; lk_addr = p; lk_wd = '0;
    unique case (st)
      S_START: begin
        len_addr = sab_pkg::state_t'(sc + 1'b1);
        len_we = (sym < sab_pkg::SYM_LIMIT) && (last_len < sab_pkg::LEN_LIMIT)
                 && (sc < sab_pkg::LAST_COUNT);
      end
      S_CLR: begin
        tr_we = 1'b1; tr_addr = {clr_row, col}; tr_wd = '0;
      end
      S_W_CHK: begin
        len_addr = tr_rd;
        if (tr_rd == '0) begin
          tr_we = 1'b1;
          if (p == '0) begin
            lk_we = 1'b1; lk_addr = cur; lk_wd = '0;
          end
        end
      end
      S_Q2: len_addr = p;
      S_Q3: begin
        if (len_q == sab_pkg::state_t'(len_p + 1'b1)) begin
          lk_we = 1'b1; lk_addr = cur; lk_wd = q;
        end else begin
          len_we = 1'b1; len_addr = sab_pkg::state_t'(sc + 1'b1);
          len_wd = sab_pkg::state_t'(len_p + 1'b1);
          lk_addr = q;
        end
      end
      S_CL1: begin lk_we = 1'b1; lk_addr = cl; lk_wd = lk_rd; end
      S_CL2: begin lk_we = 1'b1; lk_addr = q; lk_wd = cl; end
      S_CL3: begin lk_we = 1'b1; lk_addr = cur; lk_wd = cl; end
      S_CP_RD: tr_addr = {q, col};
      S_CP_WR: begin tr_we = 1'b1; tr_addr = {cl, col}; tr_wd = tr_rd; end
      S_R_CHK: begin
        tr_wd = cl;
        tr_we = (tr_rd == q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR; ret <= S_IDLE; clr_row <= '0; col <= '0;
      sc <= '0; last <= '0; last_len <= '0; last_link <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && m_tready && st != S_DONE) o_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            sym <= s_tdata[sab_pkg::CW-1:0];
            if (s_tuser[0]) begin
              sc <= '0; last <= '0; last_len <= '0; last_link <= '0;
              clr_row <= '0; col <= '0; ret <= S_START; st <= S_CLR;
            end else begin
              st <= S_START;
            end
          end
        end
        S_START: begin
          r_state <= last; r_len <= last_len; r_link <= last_link;
          r_sub <= '0; r_clone <= 1'b0; r_ovf <= 1'b0;
          if (sym >= sab_pkg::SYM_LIMIT) begin
            st <= S_DONE;
          end else if (last_len >= sab_pkg::LEN_LIMIT || sc >= sab_pkg::LAST_COUNT) begin
            r_ovf <= 1'b1; st <= S_DONE;
          end else begin
            cur <= sab_pkg::state_t'(sc + 1'b1);
            sc <= sab_pkg::state_t'(sc + 1'b1);
            clr_row <= sab_pkg::state_t'(sc + 1'b1);
            cur_len <= sab_pkg::state_t'(last_len + 1'b1);
            p <= last; col <= '0; ret <= S_W_RD; st <= S_CLR;
          end
        end
        S_CLR: begin
          col <= col + 1'b1;
          if (col == sab_pkg::LAST_COL) st <= ret;
        end
        S_W_RD: st <= S_W_CHK;
        S_W_CHK: begin
          if (tr_rd == '0) begin
            if (p == '0) begin
              r_state <= cur; r_len <= cur_len; r_link <= '0; r_sub <= cur_len;
              last <= cur; last_len <= cur_len; last_link <= '0;
              st <= S_DONE;
            end else begin
              st <= S_W_LNK;
            end
          end else begin
            q <= tr_rd; st <= S_Q2;
          end
        end
        S_W_LNK: begin p <= lk_rd; st <= S_W_RD; end
        S_Q2: begin len_q <= len_rd; st <= S_Q3; end
        S_Q3: begin
          if (len_q == sab_pkg::state_t'(len_p + 1'b1)) begin
            r_state <= cur; r_len <= cur_len; r_link <= q;
            r_sub <= sab_pkg::state_t'(cur_len - len_q);
            last <= cur; last_len <= cur_len; last_link <= q;
            st <= S_DONE;
          end else begin
            cl <= sab_pkg::state_t'(sc + 1'b1);
            sc <= sab_pkg::state_t'(sc + 1'b1);
            cl_len <= sab_pkg::state_t'(len_p + 1'b1);
            st <= S_CL1;
          end
        end
        S_CL1: st <= S_CL2;
        S_CL2: st <= S_CL3;
        S_CL3: begin col <= '0; st <= S_CP_RD; end
        S_CP_RD: st <= S_CP_WR;
        S_CP_WR: begin
          col <= col + 1'b1;
          st <= (col == sab_pkg::LAST_COL) ? S_R_RD : S_CP_RD;
        end
        S_R_RD: st <= S_R_CHK;
        S_R_CHK: begin
          if (tr_rd == q && p != '0) begin
            st <= S_R_LNK;
          end else begin
            r_state <= cur; r_len <= cur_len; r_link <= cl; r_clone <= 1'b1;
            r_sub <= sab_pkg::state_t'(cur_len - cl_len);
            last <= cur; last_len <= cur_len; last_link <= cl;
            st <= S_DONE;
          end
        end
        S_R_LNK: begin p <= lk_rd; st <= S_R_RD; end
        S_DONE: begin
          if (!o_valid || m_tready) begin
            o_data <= {r_sub, r_link, r_len, r_state};
            o_user <= {r_ovf, r_clone};
            o_valid <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // the state count always covers the last state
  a_count: assert property (@(posedge clk) disable iff (rst) sc >= last)
    else $error("state count below last state");
  // the clone is the newest state while its row is copied
  a_clone: assert property (@(posedge clk) disable iff (rst) (st == S_CP_WR) |-> (cl == sc))
    else $error("clone is not the newest state");
  // an overflow word reports the current last state until the next word starts
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE && o_valid && o_user[1]) |-> (o_data[10:0] == last))
    else $error("overflow word does not report the last state");
endmodule
`default_nettype wire

[verif/suffix_automaton_builder_tb.sv]
// suffix_automaton_builder_tb: self-checking bench for the suffix automaton builder
// depends on sab_pkg and suffix_automaton_builder; keeps its own automaton to predict results
`timescale 1ns / 1ps
`default_nettype none
module suffix_automaton_builder_tb;

  typedef struct packed {
    logic       restart;
    logic [4:0] symbol;
  } sym_word_t;

  typedef struct packed {
    sab_pkg::state_t new_state;
    sab_pkg::state_t prefix_length;
    sab_pkg::state_t suffix_link;
    logic            clone_made;
    sab_pkg::state_t new_substrings;
    logic            overflow;
  } sam_result_t;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0] m_tuser;

  suffix_automaton_builder i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow automaton
  sab_pkg::state_t sam_next [sab_pkg::NSTATES][sab_pkg::ALPHABET];
  sab_pkg::state_t sam_len [sab_pkg::NSTATES];
  int     sam_link [sab_pkg::NSTATES];
  int     sam_count;
  int     sam_last;

  sym_word_t   pending_words[$];
  sam_result_t expected_results[$];
  int total_words;
  int words_in;
  int results_out;
  int errors;
  int clones_seen;
  int overflows_seen;
  int ignored_seen;
  int restarts_seen;
  int cycle_count;
  bit hold_armed;
  int hold_left;

  function automatic void empty_sam();
    sam_count = 0;
    sam_last = 0;
    sam_len[0] = '0;
    sam_link[0] = -1;
    for (int a = 0; a < sab_pkg::ALPHABET; a++) sam_next[0][a] = '0;
  endfunction

  function automatic sam_result_t describe(int st, logic cl, logic ovf);
    sam_result_t r;
    int lk;
    lk = sam_link[st];
    r.new_state = sab_pkg::state_t'(st);
    r.prefix_length = sam_len[st];
    r.suffix_link = (lk < 0) ? '0 : sab_pkg::state_t'(lk);
    r.clone_made = cl;
    r.new_substrings = (lk < 0) ? '0 : sab_pkg::state_t'(sam_len[st] - sam_len[lk]);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic sam_result_t extend_sam(sym_word_t w);
    sam_result_t r;
    int c;
    int p;
    int cur;
    int q;
    int cl;
    if (w.restart) empty_sam();
    c = int'(w.symbol);
    // ignored symbols report the last state with no new substrings
    if (c >= sab_pkg::ALPHABET) begin
      r = describe(sam_last, 1'b0, 1'b0);
      r.new_substrings = '0;
      return r;
    end
    if (sam_len[sam_last] >= sab_pkg::LEN_LIMIT || sam_count + 2 > sab_pkg::NSTATES - 1) begin
      r = describe(sam_last, 1'b0, 1'b1);
      r.new_substrings = '0;
      return r;
    end
    p = sam_last;
    sam_count++;
    cur = sam_count;
    sam_last = cur;
    sam_len[cur] = sam_len[p] + 1'b1;
    for (int a = 0; a < sab_pkg::ALPHABET; a++) sam_next[cur][a] = '0;
    while (p >= 0 && sam_next[p][c] == '0) begin
      sam_next[p][c] = sab_pkg::state_t'(cur);
      p = sam_link[p];
    end
    if (p < 0) begin
      sam_link[cur] = 0;
      return describe(cur, 1'b0, 1'b0);
    end
    q = int'(sam_next[p][c]);
    if (sam_len[q] == sam_len[p] + 1'b1) begin
      sam_link[cur] = q;
      return describe(cur, 1'b0, 1'b0);
    end
    sam_count++;
    cl = sam_count;
    sam_len[cl] = sam_len[p] + 1'b1;
    for (int a = 0; a < sab_pkg::ALPHABET; a++) sam_next[cl][a] = sam_next[q][a];
    sam_link[cl] = sam_link[q];
    sam_link[q] = cl;
    sam_link[cur] = cl;
    while (p >= 0 && int'(sam_next[p][c]) == q) begin
      sam_next[p][c] = sab_pkg::state_t'(cl);
      p = sam_link[p];
    end
    return describe(cur, 1'b1, 1'b0);
  endfunction

  function automatic void queue_word(int sym, bit rs);
    sym_word_t w;
    w.symbol = 5'(sym);
    w.restart = rs;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // idle percentages per phase: sender 11 / receiver 52, then swapped, then none
  function automatic int phase_of();
    if (words_in < total_words / 3) return 0;
    if (words_in < 2 * total_words / 3) return 1;
    return 2;
  endfunction

  // driver
  always @(posedge clk) begin
    sam_result_t r;
    int pct;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r = extend_sam(sym_word_t'({s_tuser[0], s_tdata[4:0]}));
        expected_results.insert(expected_results.size(), r);
        words_in <= words_in + 1;
        if (s_tuser[0]) restarts_seen <= restarts_seen + 1;
      end
      if (!s_tvalid || s_tready) begin
        pct = (phase_of() == 0) ? 11 : (phase_of() == 1) ? 52 : 0;
        if (pending_words.size() > 0 && $urandom_range(99) >= pct) begin
          sym_word_t w;
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, w.symbol};
          s_tuser <= w.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off, counted in cycles; the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_armed <= 1'b1;
      hold_left <= 0;
    end else if (hold_armed && words_in == 150) begin
      hold_armed <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    sam_result_t e;
    int pct;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_out <= results_out + 1;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: tdata=%h tuser=%b", m_tdata, m_tuser);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[10:0] !== e.new_state) begin
            $error("new_state exp %0d got %0d", e.new_state, m_tdata[10:0]); errors++;
          end
          if (m_tdata[21:11] !== e.prefix_length) begin
            $error("prefix_length exp %0d got %0d", e.prefix_length, m_tdata[21:11]); errors++;
          end
          if (m_tdata[32:22] !== e.suffix_link) begin
            $error("suffix_link exp %0d got %0d", e.suffix_link, m_tdata[32:22]); errors++;
          end
          if (m_tdata[43:33] !== e.new_substrings) begin
            $error("new_substrings exp %0d got %0d", e.new_substrings, m_tdata[43:33]);
            errors++;
          end
          if (m_tuser[0] !== e.clone_made) begin
            $error("clone_made exp %0b got %0b", e.clone_made, m_tuser[0]); errors++;
          end
          if (m_tuser[1] !== e.overflow) begin
            $error("overflow exp %0b got %0b", e.overflow, m_tuser[1]); errors++;
          end
          if (e.clone_made) clones_seen++;
          if (e.overflow) overflows_seen++;
        end
      end
      pct = (phase_of() == 0) ? 52 : (phase_of() == 1) ? 11 : 0;
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("suffix_automaton_builder test failed");
      $finish;
    end
  end

  initial begin
    int n;
    int alpha;
    errors = 0;
    words_in = 0;
    results_out = 0;
    clones_seen = 0;
    overflows_seen = 0;
    ignored_seen = 0;
    restarts_seen = 0;
    cycle_count = 0;
    for (int s = 0; s < sab_pkg::NSTATES; s++) begin
      sam_len[s] = '0;
      sam_link[s] = 0;
      for (int a = 0; a < sab_pkg::ALPHABET; a++) sam_next[s][a] = '0;
    end
    empty_sam();

    // directed: extremes, out-of-range symbols, repeats that force clones, restarts
    queue_word(0, 0);
    queue_word(sab_pkg::ALPHABET - 1, 0);
    queue_word(31, 0);
    queue_word(sab_pkg::ALPHABET, 0);
    queue_word(0, 0);
    queue_word(0, 0);
    queue_word(1, 0);
    queue_word(0, 0);
    queue_word(1, 0);
    queue_word(1, 0);
    queue_word(31, 1);
    queue_word(16, 0);
    queue_word(sab_pkg::ALPHABET - 1, 1);
    queue_word(sab_pkg::ALPHABET - 1, 0);
    queue_word(2, 0);
    queue_word(sab_pkg::ALPHABET - 1, 0);
    queue_word(15, 0);
    queue_word(0, 1);

    // random segments, each starting with a restart, mostly over a small alphabet
    for (int seg = 0; seg < 30; seg++) begin
      n = $urandom_range(40, 1);
      alpha = ($urandom_range(3) == 0) ? sab_pkg::ALPHABET : $urandom_range(4, 2);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(19) == 0) queue_word($urandom_range(31, sab_pkg::ALPHABET), k == 0);
        else queue_word($urandom_range(alpha - 1), k == 0);
      end
    end
    // one long run past the length limit so capacity overflow shows up
    for (int k = 0; k < sab_pkg::MAX_LEN + 12; k++) queue_word($urandom_range(2), k == 0);
    // more mixed segments after a full automaton
    for (int seg = 0; seg < 25; seg++) begin
      n = $urandom_range(30, 1);
      alpha = $urandom_range(5, 2);
      for (int k = 0; k < n; k++) queue_word($urandom_range(alpha - 1), k == 0);
    end
    foreach (pending_words[i]) if (pending_words[i].symbol >= sab_pkg::SYM_LIMIT) ignored_seen++;
    total_words = pending_words.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_words.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("%0d symbols sent (%0d restarts, %0d out of range), %0d results checked",
             words_in, restarts_seen, ignored_seen, results_out);
    $display("%0d clones and %0d capacity overflows exercised", clones_seen, overflows_seen);
    if (errors == 0) begin
      $display("suffix_automaton_builder test passed");
    end else begin
      $display("suffix_automaton_builder test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
